/* src/aeq_pkg.sv */
`default_nettype none

package aeq_pkg;

   // Queue depth and width of the free-running tick counter.
   localparam int MAX_ALARMS = 16;
   localparam int TICK_BITS  = 16;
   localparam int IDX_W      = $clog2(MAX_ALARMS);
   localparam int CNT_W      = $clog2(MAX_ALARMS + 1);

   // Command kinds.
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_POP    = 2'd2;

   // Result status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;
   localparam logic [1:0] ST_DUP     = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  alarm_id;
      logic [15:0] expiry_tick;
      logic [15:0] now_tick;
   } aeq_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        head_valid;
      logic [3:0]  head_id;
      logic [15:0] head_expiry;
      logic [4:0]  entry_count;
   } aeq_rsp_type;

   // One stored alarm.
   typedef struct packed {
      logic [3:0]           id;
      logic [TICK_BITS-1:0] expiry;
   } aeq_slot_type;

   // Control from the sequencer to the slot memory.
   typedef struct packed {
      logic               wr_en;
      logic [IDX_W-1:0]   wr_addr;
      aeq_slot_type       wr_data;
      logic [IDX_W-1:0]   rd_addr;
   } aeq_mem_port_type;

   // Flags from the shared compare unit.
   typedef struct packed {
      logic id_hit;
      logic later;
   } aeq_cmp_type;

endpackage

`default_nettype wire

/* src/alarm_expiry_queue.sv */
// An insert scans every queued alarm, then moves the tail up past the insert position and
// writes the new alarm; a removal scans, then moves the tail down over the removed slot; a pop
// moves the tail down from slot zero. Every command ends by reading the head into the result.
// One command at a time: the sequencer reads and writes the slot memory in separate states.
// A new request is taken once the result is in the output register. Synchronous active-high
// reset empties the queue and the output.
`default_nettype none

module alarm_expiry_queue
   import aeq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire aeq_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output aeq_rsp_type      rsp_data
);

   // Sequencer states.
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SCAN_RD  = 4'd1;
   localparam logic [3:0] S_SCAN_CMP = 4'd2;
   localparam logic [3:0] S_EVAL     = 4'd3;
   localparam logic [3:0] S_UP_RD    = 4'd4;
   localparam logic [3:0] S_UP_WR    = 4'd5;
   localparam logic [3:0] S_PUT      = 4'd6;
   localparam logic [3:0] S_DN_RD    = 4'd7;
   localparam logic [3:0] S_DN_WR    = 4'd8;
   localparam logic [3:0] S_HEAD_RD  = 4'd9;
   localparam logic [3:0] S_HEAD_CAP = 4'd10;

   logic [3:0]       state_ff, state_in;
   aeq_req_type      cmd_ff, cmd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] hit_ff, hit_in;
   logic             found_ff, found_in;
   logic             pos_set_ff, pos_set_in;
   logic [1:0]       status_ff, status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   aeq_rsp_type      rsp_ff, rsp_in;

   logic [CNT_W-1:0] idx_inc;
   logic [CNT_W-1:0] idx_dec;
   aeq_mem_port_type mem_port;
   aeq_slot_type     mem_rd;
   aeq_cmp_type      cmp;

   // The slots hold the queue in order, head in slot zero. Only data from slots below
   // the fill count is ever used, so the memory needs no clearing after reset.
   aeq_slot_mem u_slot_mem (
      .clock    (clock),
      .mem_port (mem_port),
      .rd_data  (mem_rd)
   );

   // The one compare unit serves every step of a scan: it checks the id of the
   // slot just read and whether that slot expires later than the new alarm,
   // both distances taken from the command's own tick.
   aeq_cmp_unit u_cmp_unit (
      .slot       (mem_rd),
      .key_id     (cmd_ff.alarm_id),
      .key_expiry (cmd_ff.expiry_tick[TICK_BITS-1:0]),
      .now_tick   (cmd_ff.now_tick[TICK_BITS-1:0]),
      .result     (cmp)
   );

   assign idx_inc = idx_ff + 1'b1;
   assign idx_dec = idx_ff - 1'b1;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      hit_in       = hit_ff;
      found_in     = found_ff;
      pos_set_in   = pos_set_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mem_port     = '0;

      // The output register frees up when its beat is taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_data;
               idx_in     = '0;
               pos_in     = count_ff;
               hit_in     = '0;
               found_in   = 1'b0;
               pos_set_in = 1'b0;
               status_in  = ST_OK;
               case (req_data.kind)
                  KIND_INSERT, KIND_REMOVE: begin
                     state_in = (count_ff == '0) ? S_EVAL : S_SCAN_RD;
                  end
                  KIND_POP: begin
                     if (count_ff == '0) begin
                        status_in = ST_MISSING;
                        state_in  = S_HEAD_RD;
                     end else begin
                        state_in = S_DN_RD;
                     end
                  end
                  default: begin
                     // The unused kind only reports the head.
                     state_in = S_HEAD_RD;
                  end
               endcase
            end
         end

         // Scan every queued slot: note the first id match and the first slot
         // that expires strictly later than the new alarm.
         S_SCAN_RD: begin
            mem_port.rd_addr = idx_ff[IDX_W-1:0];
            state_in         = S_SCAN_CMP;
         end

         S_SCAN_CMP: begin
            if (cmp.id_hit && !found_ff) begin
               found_in = 1'b1;
               hit_in   = idx_ff;
            end
            if (cmp.later && !pos_set_ff) begin
               pos_set_in = 1'b1;
               pos_in     = idx_ff;
            end
            if (idx_inc == count_ff) begin
               state_in = S_EVAL;
            end else begin
               idx_in   = idx_inc;
               state_in = S_SCAN_RD;
            end
         end

         S_EVAL: begin
            if (cmd_ff.kind == KIND_INSERT) begin
               // A duplicate id is reported ahead of a full queue.
               if (found_ff) begin
                  status_in = ST_DUP;
                  state_in  = S_HEAD_RD;
               end else if (count_ff == CNT_W'(MAX_ALARMS)) begin
                  status_in = ST_FULL;
                  state_in  = S_HEAD_RD;
               end else if (pos_ff == count_ff) begin
                  state_in = S_PUT;
               end else begin
                  idx_in   = count_ff;
                  state_in = S_UP_RD;
               end
            end else begin
               if (!found_ff) begin
                  status_in = ST_MISSING;
                  state_in  = S_HEAD_RD;
               end else begin
                  idx_in   = hit_ff;
                  state_in = S_DN_RD;
               end
            end
         end

         // Open a gap at the insert position, moving the tail up one slot.
         S_UP_RD: begin
            mem_port.rd_addr = idx_dec[IDX_W-1:0];
            state_in         = S_UP_WR;
         end

         S_UP_WR: begin
            mem_port.wr_en   = 1'b1;
            mem_port.wr_addr = idx_ff[IDX_W-1:0];
            mem_port.wr_data = mem_rd;
            idx_in           = idx_dec;
            state_in         = (idx_dec == pos_ff) ? S_PUT : S_UP_RD;
         end

         S_PUT: begin
            mem_port.wr_en          = 1'b1;
            mem_port.wr_addr        = pos_ff[IDX_W-1:0];
            mem_port.wr_data.id     = cmd_ff.alarm_id;
            mem_port.wr_data.expiry = cmd_ff.expiry_tick[TICK_BITS-1:0];
            count_in                = count_ff + 1'b1;
            state_in                = S_HEAD_RD;
         end

         // Close the hole left by a removed alarm, moving the tail down.
         S_DN_RD: begin
            if (idx_inc >= count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_HEAD_RD;
            end else begin
               mem_port.rd_addr = idx_inc[IDX_W-1:0];
               state_in         = S_DN_WR;
            end
         end

         S_DN_WR: begin
            mem_port.wr_en   = 1'b1;
            mem_port.wr_addr = idx_ff[IDX_W-1:0];
            mem_port.wr_data = mem_rd;
            idx_in           = idx_inc;
            state_in         = S_DN_RD;
         end

         S_HEAD_RD: begin
            mem_port.rd_addr = '0;
            state_in         = S_HEAD_CAP;
         end

         // Hold the head read until the output register can take the result.
         S_HEAD_CAP: begin
            mem_port.rd_addr = '0;
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = status_ff;
               rsp_in.entry_count = 5'(count_ff);
               if (count_ff != '0) begin
                  rsp_in.head_valid  = 1'b1;
                  rsp_in.head_id     = mem_rd.id;
                  rsp_in.head_expiry = 16'(mem_rd.expiry);
               end else begin
                  rsp_in.head_valid  = 1'b0;
                  rsp_in.head_id     = '0;
                  rsp_in.head_expiry = '0;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff     <= cmd_in;
      idx_ff     <= idx_in;
      pos_ff     <= pos_in;
      hit_ff     <= hit_in;
      found_ff   <= found_in;
      pos_set_ff <= pos_set_in;
      status_ff  <= status_in;
      rsp_ff     <= rsp_in;
   end

   // A request beat is taken only while the sequencer is idle.
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* src/aeq_slot_mem.sv */
`default_nettype none

module aeq_slot_mem
   import aeq_pkg::*;
(
   input  wire logic             clock,
   input  wire aeq_mem_port_type mem_port,
   output aeq_slot_type          rd_data
);

   aeq_slot_type slots_ff [MAX_ALARMS];
   aeq_slot_type rd_data_ff;

   // One write port and one read port; read data is registered.
   always_ff @(posedge clock) begin
      if (mem_port.wr_en) begin
         slots_ff[mem_port.wr_addr] <= mem_port.wr_data;
      end
      rd_data_ff <= slots_ff[mem_port.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/aeq_cmp_unit.sv */
`default_nettype none

module aeq_cmp_unit
   import aeq_pkg::*;
(
   input  wire aeq_slot_type         slot,
   input  wire logic [3:0]           key_id,
   input  wire logic [TICK_BITS-1:0] key_expiry,
   input  wire logic [TICK_BITS-1:0] now_tick,
   output aeq_cmp_type               result
);

   logic [TICK_BITS-1:0] slot_dist;
   logic [TICK_BITS-1:0] key_dist;

   // Distances to expiry wrap modulo the counter range.
   assign slot_dist     = slot.expiry - now_tick;
   assign key_dist      = key_expiry - now_tick;
   assign result.id_hit = (slot.id == key_id);
   assign result.later  = (slot_dist > key_dist);

endmodule

`default_nettype wire

/* src/aeq_checker.sv */
`default_nettype none

module aeq_checker
   import aeq_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire aeq_rsp_type rsp_data
);

   // The output is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // The head is valid exactly when the queue is not empty.
   a_head_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.head_valid == (rsp_data.entry_count != 5'd0)))
      else $error("head valid disagrees with entry count");

   // The queue never reports more alarms than its depth.
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.entry_count <= 5'(MAX_ALARMS)))
      else $error("entry count above queue depth");

   // An empty queue reports a zero head.
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.head_valid |->
         (rsp_data.head_id == 4'd0) && (rsp_data.head_expiry == 16'd0))
      else $error("empty queue reports a nonzero head");

endmodule

bind alarm_expiry_queue aeq_checker u_aeq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* tb/alarm_expiry_queue_test.sv */
`timescale 1ns / 100ps

module alarm_expiry_queue_test;
   import aeq_pkg::*;

   // The package names three command kinds; the fourth encoding is a no-op that
   // still returns the current head.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // A quiet stretch longer than this means the block has hung. The longest
   // legal one is the receiver hold-off plus one worst-case command.
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_OFF_CYCLES = 400;
   // Worst-case command latency with some margin, waited out at the end so a
   // stray extra result beat is still caught.
   localparam int DRAIN_CYCLES    = 4 * MAX_ALARMS + 16;
   localparam int ITEMS_PER_PHASE = 106;

   typedef struct {
      aeq_req_type cmd;
      bit          typed;
      aeq_rsp_type rsp;
   } directed_row_type;

   typedef struct {
      int          beat_no;
      aeq_rsp_type rsp;
   } awaited_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   aeq_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   aeq_rsp_type rsp_data;

   int mismatch_count;
   int beat_count;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_off_asked;
   int insert_pct;
   int quiet_cycles;
   logic [TICK_BITS-1:0] tick_now;

   directed_row_type   directed_rows[$];
   awaited_result_type awaited_results[$];

   // The alarm queue as the block should hold it, head in entry 0.
   logic [3:0]           alarm_ids[MAX_ALARMS];
   logic [TICK_BITS-1:0] alarm_expiries[MAX_ALARMS];
   int                   alarm_count;

   alarm_expiry_queue i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Distance to expiry is measured forward from the current tick, so an expiry
   // just behind the counter lands at the far end of the order.
   function automatic logic [TICK_BITS-1:0] ticks_to_expiry(
      input logic [TICK_BITS-1:0] expiry,
      input logic [TICK_BITS-1:0] now
   );
      return expiry - now;
   endfunction

   function automatic int find_alarm(input logic [3:0] id);
      for (int i = 0; i < alarm_count; i++) begin
         if (alarm_ids[i] == id) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic void drop_alarm(input int pos);
      for (int i = pos; i < alarm_count - 1; i++) begin
         alarm_ids[i]      = alarm_ids[i + 1];
         alarm_expiries[i] = alarm_expiries[i + 1];
      end
      alarm_count--;
   endfunction

   // Applies one command to the expected queue and returns the result beat the
   // block must produce for it.
   function automatic aeq_rsp_type apply_command(input aeq_req_type cmd);
      aeq_rsp_type          rsp;
      int                   pos;
      logic [TICK_BITS-1:0] new_gap;
      rsp = '0;
      rsp.status = ST_OK;
      case (cmd.kind)
         KIND_INSERT: begin
            // The duplicate check comes first. With 16 ids and 16 slots a full
            // queue always holds the id too, so a full insert reports a duplicate.
            if (find_alarm(cmd.alarm_id) >= 0) begin
               rsp.status = ST_DUP;
            end else if (alarm_count >= MAX_ALARMS) begin
               rsp.status = ST_FULL;
            end else begin
               new_gap = ticks_to_expiry(cmd.expiry_tick, cmd.now_tick);
               pos     = 0;
               // Equal distances keep arrival order: scan past every entry that
               // is not strictly later, measured from this command's tick.
               while (pos < alarm_count &&
                      ticks_to_expiry(alarm_expiries[pos], cmd.now_tick) <= new_gap) begin
                  pos++;
               end
               for (int i = alarm_count; i > pos; i--) begin
                  alarm_ids[i]      = alarm_ids[i - 1];
                  alarm_expiries[i] = alarm_expiries[i - 1];
               end
               alarm_ids[pos]      = cmd.alarm_id;
               alarm_expiries[pos] = cmd.expiry_tick;
               alarm_count++;
            end
         end
         KIND_REMOVE: begin
            pos = find_alarm(cmd.alarm_id);
            if (pos < 0) begin
               rsp.status = ST_MISSING;
            end else begin
               drop_alarm(pos);
            end
         end
         KIND_POP: begin
            if (alarm_count == 0) begin
               rsp.status = ST_MISSING;
            end else begin
               drop_alarm(0);
            end
         end
         default: begin
         end
      endcase
      if (alarm_count > 0) begin
         rsp.head_valid  = 1'b1;
         rsp.head_id     = alarm_ids[0];
         rsp.head_expiry = alarm_expiries[0];
      end
      rsp.entry_count = CNT_W'(alarm_count);
      return rsp;
   endfunction

   // Rows with typed set carry a result that can be read off by hand; the rest
   // are checked against apply_command.
   function automatic void add_row(
      input logic [1:0]  kind,
      input logic [3:0]  id,
      input logic [15:0] expiry,
      input logic [15:0] now,
      input bit          typed = 1'b0,
      input logic [1:0]  status = ST_OK,
      input logic        head_valid = 1'b0,
      input logic [3:0]  head_id = 4'd0,
      input logic [15:0] head_expiry = 16'h0000,
      input logic [4:0]  entry_count = 5'd0
   );
      directed_row_type row;
      row.cmd.kind         = kind;
      row.cmd.alarm_id     = id;
      row.cmd.expiry_tick  = expiry;
      row.cmd.now_tick     = now;
      row.typed            = typed;
      row.rsp.status       = status;
      row.rsp.head_valid   = head_valid;
      row.rsp.head_id      = head_id;
      row.rsp.head_expiry  = head_expiry;
      row.rsp.entry_count  = entry_count;
      directed_rows.push_back(row);
   endfunction

   // Random commands are mostly well formed: the counter creeps forward, most
   // removals name a queued alarm, and inserts often land next to or level with
   // existing expiries. The insert share drifts so the queue both fills and drains.
   function automatic aeq_req_type random_command();
      aeq_req_type cmd;
      int          r;
      cmd.alarm_id    = 4'($urandom_range(15));
      cmd.expiry_tick = 16'($urandom_range(65535));
      if ($urandom_range(9) == 0) begin
         tick_now = 16'($urandom_range(65535));
      end else begin
         tick_now = tick_now + 16'($urandom_range(40));
      end
      cmd.now_tick = tick_now;
      r = $urandom_range(99);
      if (r < 4) begin
         cmd.kind = KIND_UNUSED;
      end else if (r < 4 + insert_pct) begin
         cmd.kind = KIND_INSERT;
         case ($urandom_range(3))
            0: cmd.expiry_tick = tick_now + 16'($urandom_range(255));
            1: begin
               if (alarm_count > 0) begin
                  cmd.expiry_tick = alarm_expiries[$urandom_range(alarm_count - 1)];
               end
            end
            2: begin
            end
            default: cmd.expiry_tick = tick_now - 16'($urandom_range(255));
         endcase
      end else if ($urandom_range(1) == 0) begin
         cmd.kind = KIND_REMOVE;
         if (alarm_count > 0 && $urandom_range(3) != 0) begin
            cmd.alarm_id = alarm_ids[$urandom_range(alarm_count - 1)];
         end
      end else begin
         cmd.kind = KIND_POP;
      end
      return cmd;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(
      input int          beat_no,
      input string       field,
      input logic [31:0] got,
      input logic [31:0] want
   );
      if (got !== want) begin
         report_mismatch($sformatf("result of command beat %0d, %s: got %0h, expected %0h",
                                   beat_no, field, got, want));
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the beat is
   // taken. The idle gap, if any, is spent with valid low.
   task automatic offer_command(
      input aeq_req_type cmd,
      input bit          typed,
      input aeq_rsp_type typed_rsp
   );
      awaited_result_type awaited;
      aeq_rsp_type        predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_data  <= aeq_req_type'($urandom());
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predicted       = apply_command(cmd);
      awaited.beat_no = beat_count;
      awaited.rsp     = typed ? typed_rsp : predicted;
      awaited_results.push_back(awaited);
      beat_count++;
      @(negedge clock);
   endtask

   // Result beats are checked at the rising edge where they are taken.
   always @(posedge clock) begin
      awaited_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("result beat %h with no command outstanding",
                                      rsp_data));
         end else begin
            want = awaited_results.pop_front();
            compare_field(want.beat_no, "status", 32'(rsp_data.status),
                          32'(want.rsp.status));
            compare_field(want.beat_no, "head_valid", 32'(rsp_data.head_valid),
                          32'(want.rsp.head_valid));
            compare_field(want.beat_no, "head_id", 32'(rsp_data.head_id),
                          32'(want.rsp.head_id));
            compare_field(want.beat_no, "head_expiry", 32'(rsp_data.head_expiry),
                          32'(want.rsp.head_expiry));
            compare_field(want.beat_no, "entry_count", 32'(rsp_data.entry_count),
                          32'(want.rsp.entry_count));
         end
      end
   end

   // Counts cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver side. A hold-off request makes it stall for a long fixed stretch,
   // counted here, so the block ends up holding a result and stalling its input
   // while the sender keeps offering.
   initial begin : receiver
      int held_left;
      int hold_off_seen;
      held_left     = 0;
      hold_off_seen = 0;
      rsp_stall     = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_asked != hold_off_seen) begin
            hold_off_seen = hold_off_asked;
            held_left     = HOLD_OFF_CYCLES;
         end
         if (held_left > 0) begin
            held_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   initial begin : stimulus
      int          send_idle_by_phase[4];
      int          recv_stall_by_phase[4];
      aeq_rsp_type no_rsp;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      mismatch_count = 0;
      beat_count     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_asked = 0;
      insert_pct     = 50;
      alarm_count    = 0;
      tick_now       = '0;
      no_rsp         = '0;

      // Phases: no idling, sender idle, receiver stalling, both idling a little.
      send_idle_by_phase  = '{0, 86, 0, 13};
      recv_stall_by_phase = '{0, 0, 86, 13};

      // Commands against an empty queue: pop, unknown id and the unused kind.
      add_row(KIND_POP, 4'd0, 16'h0000, 16'h0000, 1'b1, ST_MISSING);
      add_row(KIND_REMOVE, 4'd9, 16'h0000, 16'h0000, 1'b1, ST_MISSING);
      add_row(KIND_UNUSED, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1, ST_OK);
      // Farthest possible expiry first, then a duplicate of it, then an alarm
      // due right now, which must go to the head.
      add_row(KIND_INSERT, 4'd15, 16'hFFFF, 16'h0000, 1'b1, ST_OK, 1'b1, 4'd15,
              16'hFFFF, 5'd1);
      add_row(KIND_INSERT, 4'd15, 16'h1234, 16'h0000, 1'b1, ST_DUP, 1'b1, 4'd15,
              16'hFFFF, 5'd1);
      add_row(KIND_INSERT, 4'd0, 16'h0000, 16'h0000, 1'b1, ST_OK, 1'b1, 4'd0,
              16'h0000, 5'd2);
      // Expiry past the counter wrap, seen from a tick just below it.
      add_row(KIND_INSERT, 4'd1, 16'h0010, 16'hFFF0);
      // Same distance as an entry already queued: goes in after it.
      add_row(KIND_INSERT, 4'd2, 16'h0000, 16'hFFF0);
      // Distances measured from a tick far from the one the queue was built with.
      add_row(KIND_INSERT, 4'd3, 16'h8000, 16'h4000);
      // Fill the queue to its last slot.
      for (int i = 4; i < 15; i++) begin
         add_row(KIND_INSERT, 4'(i), 16'(i * 16'h1111), 16'(i * 16'h0F0F));
      end
      // Insert into a full queue; the id is necessarily queued already.
      add_row(KIND_INSERT, 4'd7, 16'hFFFF, 16'h0000);
      add_row(KIND_REMOVE, 4'd3, 16'h0000, 16'h0000);
      add_row(KIND_REMOVE, 4'd3, 16'hFFFF, 16'hFFFF);
      add_row(KIND_UNUSED, 4'd0, 16'h0000, 16'h0000);
      add_row(KIND_POP, 4'd15, 16'hFFFF, 16'hFFFF);

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         offer_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].rsp);
      end

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = send_idle_by_phase[phase];
         recv_stall_pct = recv_stall_by_phase[phase];
         // Back-pressure test at the start of the busiest phase.
         if (phase == 0) begin
            hold_off_asked++;
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 40 == 0) begin
               insert_pct = $urandom_range(75, 25);
            end
            offer_command(random_command(), 1'b0, no_rsp);
         end
      end
      req_valid <= 1'b0;

      while (awaited_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
